// ===== rtl/core/ntfs_pkg.sv =====
// shared types, character codes and digit helpers for the nmea time/fix/snr parser
package ntfs_pkg;

  // item kinds on the input channel
  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_TICK = 1'b1
  } kind_e;

  // sentence framing characters
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;

  // sentence id letters
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_V = 8'h56;
  localparam logic [7:0] CH_Z = 8'h5A;

  // parse positions
  localparam logic [7:0] POS_IDLE     = 8'd0;
  localparam logic [7:0] POS_START    = 8'd1;
  localparam logic [7:0] POS_ID_FIRST = 8'd3;
  localparam logic [7:0] POS_ID_SECND = 8'd4;
  localparam logic [7:0] POS_ID_THIRD = 8'd5;
  localparam logic [7:0] POS_FIELDS   = 8'd6;
  localparam logic [7:0] FIELD_BASE   = 8'd7;

  // field numbers of interest
  localparam logic [7:0] FLD_FIRST       = 8'd0;
  localparam logic [7:0] FLD_ZDA_DAY     = 8'd1;
  localparam logic [7:0] FLD_ZDA_MONTH   = 8'd2;
  localparam logic [7:0] FLD_ZDA_YEAR    = 8'd3;
  localparam logic [7:0] FLD_GGA_QUALITY = 8'd5;
  localparam logic [7:0] FLD_GSV_SNR0    = 8'd6;
  localparam logic [7:0] FLD_GSV_SNR1    = 8'd10;
  localparam logic [7:0] FLD_GSV_SNR2    = 8'd14;
  localparam logic [7:0] FLD_GSV_SNR3    = 8'd18;

  // storage sizes and fixed values
  localparam int unsigned KEPT_BYTES = 6;
  localparam logic [7:0]  SNR_LIMIT  = 8'd100;
  localparam logic [15:0] HOLD_RESET = 16'd1100;
  localparam int unsigned SUM_W      = 11;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] rx_byte;
  } ntfs_in_t;

  typedef struct packed {
    logic [7:0]       utc_hours;
    logic [7:0]       utc_minutes;
    logic [7:0]       utc_seconds;
    logic [7:0]       utc_day;
    logic [7:0]       utc_month;
    logic [15:0]      utc_year;
    logic             fix_ok;
    logic             time_ok;
    logic [SUM_W-1:0] signal_sum;
  } ntfs_out_t;

  // two ascii digits to a wrapping 8-bit value
  function automatic logic [7:0] two_digits(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] dh;
    logic [7:0] dl;
    dh = hi - CH_ZERO;
    dl = lo - CH_ZERO;
    return 8'(dh * 8'd10) + dl;
  endfunction

  // four ascii digits to a wrapping 16-bit year
  function automatic logic [15:0] four_digits(input logic [7:0] d0, input logic [7:0] d1,
                                              input logic [7:0] d2, input logic [7:0] d3);
    logic [15:0] v0;
    logic [15:0] v1;
    logic [15:0] v2;
    logic [15:0] v3;
    v0 = {8'd0, d0} - {8'd0, CH_ZERO};
    v1 = {8'd0, d1} - {8'd0, CH_ZERO};
    v2 = {8'd0, d2} - {8'd0, CH_ZERO};
    v3 = {8'd0, d3} - {8'd0, CH_ZERO};
    return 16'(v0 * 16'd1000) + 16'(v1 * 16'd100) + 16'(v2 * 16'd10) + v3;
  endfunction

endpackage

// ===== rtl/core/ntfs_in_if.sv =====
// input channel: bytes and millisecond ticks with valid/ready
interface ntfs_in_if;
  import ntfs_pkg::*;

  logic     valid;
  logic     ready;
  ntfs_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/ntfs_out_if.sv =====
// output channel: time, fix and signal status with valid/ready
interface ntfs_out_if;
  import ntfs_pkg::*;

  logic      valid;
  logic      ready;
  ntfs_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/nmea_time_fix_snr_parser.sv =====
// nmea sentence parser: zda time, gga fix hold, gsv best-snr sum
// A result is in the output register from the cycle after its input transfer.
// Throughput: one item per cycle while results are taken; the output register lets a
// new item in only when it is empty or its waiting result is taken in the same cycle.
// Reset: parser idle, timers, time fields, sum and snr count cleared, hold time 1100 ms;
// snr entries are unreset and only read once written.
module nmea_time_fix_snr_parser #(
  parameter int unsigned BEST_SATS = 5,
  parameter int unsigned FIELD_MAX = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  ntfs_in_if.sink             in_i,
  ntfs_out_if.source          out_o
);
  import ntfs_pkg::*;

  localparam int unsigned FLW  = $clog2(FIELD_MAX + 1);
  localparam int unsigned SCW  = $clog2(BEST_SATS + 1);
  localparam int unsigned SIW  = (BEST_SATS > 1) ? $clog2(BEST_SATS) : 1;
  localparam int unsigned NPAD = 1 << SIW;

  typedef struct packed {
    logic           hit;
    logic [7:0]     val;
    logic [SIW-1:0] idx;
  } node_t;

  // state
  logic [15:0]      hold_q;
  logic [7:0]       pos_q, pos_d;
  logic [7:0]       talker_q [3];
  logic [7:0]       talker_d [3];
  logic [FLW-1:0]   flen_q, flen_d;
  logic [7:0]       fbytes_q [KEPT_BYTES];
  logic [7:0]       fbytes_d [KEPT_BYTES];
  logic [15:0]      fix_q, fix_d;
  logic [15:0]      time_q, time_d;
  logic [7:0]       snr_q [BEST_SATS];
  logic [7:0]       snr_d [BEST_SATS];
  logic [SCW-1:0]   cnt_q, cnt_d;
  logic [SUM_W-1:0] strength_q, strength_d;
  logic [7:0]       clock_q [5];
  logic [7:0]       clock_d [5];
  logic [15:0]      year_q, year_d;

  // output register
  logic      out_valid_q;
  ntfs_out_t out_q;
  ntfs_out_t out_d;

  logic       accept;
  logic [7:0] c;
  logic       do_close;
  logic       close_ok;
  logic [7:0] num;
  logic       is_gga, is_zda, is_gsv;
  logic [7:0] fb_eff [KEPT_BYTES];
  logic [7:0] snr_new;
  logic [SUM_W-1:0] sum;
  node_t      heap [1:2*NPAD-1];
  logic [SIW-1:0] vic_idx;
  logic [7:0]     vic_val;

  // handshake: output register frees up when its result is taken
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign c          = in_i.data.rx_byte;

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // field bytes with the terminator placed at the field length
  always_comb begin
    for (int k = 0; k < KEPT_BYTES; k++) begin
      fb_eff[k] = (flen_q == FLW'(k)) ? 8'd0 : fbytes_q[k];
    end
  end

  assign close_ok = (flen_q != '0) && (flen_q < FLW'(FIELD_MAX));
  assign num      = pos_q - FIELD_BASE;
  assign is_gga   = talker_q[0] == CH_G && talker_q[1] == CH_G && talker_q[2] == CH_A;
  assign is_zda   = talker_q[0] == CH_Z && talker_q[1] == CH_D && talker_q[2] == CH_A;
  assign is_gsv   = talker_q[0] == CH_G && talker_q[1] == CH_S && talker_q[2] == CH_V;
  assign snr_new  = two_digits(fb_eff[0], fb_eff[1]);

  // sum of the filled snr entries
  always_comb begin
    sum = '0;
    for (int i = 0; i < BEST_SATS; i++) begin
      if (SCW'(i) < cnt_q) begin
        sum = sum + SUM_W'(snr_q[i]);
      end
    end
  end

  // min tree: first smallest entry below the limit, ties keep the lower index
  always_comb begin
    for (int i = 0; i < BEST_SATS; i++) begin
      heap[NPAD+i] = '{hit: snr_q[i] < SNR_LIMIT, val: snr_q[i], idx: SIW'(i)};
    end
    for (int i = BEST_SATS; i < NPAD; i++) begin
      heap[NPAD+i] = '{hit: 1'b0, val: 8'd0, idx: SIW'(i)};
    end
    for (int n = NPAD - 1; n >= 1; n--) begin
      if (heap[2*n+1].hit && (!heap[2*n].hit || heap[2*n+1].val < heap[2*n].val)) begin
        heap[n] = heap[2*n+1];
      end else begin
        heap[n] = heap[2*n];
      end
    end
  end

  assign vic_idx = heap[1].hit ? heap[1].idx : '0;
  assign vic_val = heap[1].hit ? heap[1].val : snr_q[0];

  // next state for one accepted item
  always_comb begin
    pos_d      = pos_q;
    talker_d   = talker_q;
    flen_d     = flen_q;
    fbytes_d   = fbytes_q;
    fix_d      = fix_q;
    time_d     = time_q;
    snr_d      = snr_q;
    cnt_d      = cnt_q;
    strength_d = strength_q;
    clock_d    = clock_q;
    year_d     = year_q;
    do_close   = 1'b0;

    if (in_i.data.kind == KIND_TICK) begin
      if (fix_q != '0) begin
        fix_d = fix_q - 16'd1;
      end
      if (time_q != '0) begin
        time_d = time_q - 16'd1;
      end
    end else if (c == CH_DOLLAR) begin
      pos_d = POS_START;
    end else if (c == CH_STAR) begin
      do_close = 1'b1;
      flen_d   = '0;
      pos_d    = POS_IDLE;
    end else if (pos_q == POS_IDLE) begin
      pos_d = POS_IDLE;
    end else if (pos_q < POS_FIELDS) begin
      case (pos_q)
        POS_ID_FIRST: talker_d[0] = c;
        POS_ID_SECND: talker_d[1] = c;
        POS_ID_THIRD: talker_d[2] = c;
        default: ;
      endcase
      pos_d = pos_q + 8'd1;
    end else if (c == CH_COMMA) begin
      do_close = 1'b1;
      flen_d   = '0;
      pos_d    = pos_q + 8'd1;
    end else if (flen_q < FLW'(FIELD_MAX)) begin
      for (int k = 0; k < KEPT_BYTES; k++) begin
        if (flen_q == FLW'(k)) begin
          fbytes_d[k] = c;
        end
      end
      flen_d = flen_q + FLW'(1);
    end

    // field close: dispatch on sentence type and field number
    if (do_close && close_ok) begin
      fbytes_d = fb_eff;
      if (is_gga) begin
        if (num == FLD_GGA_QUALITY) begin
          fix_d = (fb_eff[0] == CH_ONE && fb_eff[1] == 8'd0) ? hold_q : 16'd0;
        end else if (num == FLD_FIRST) begin
          strength_d = sum;
          cnt_d      = '0;
        end
      end else if (is_zda) begin
        if (num == FLD_FIRST) begin
          clock_d[0] = two_digits(fb_eff[0], fb_eff[1]);
          clock_d[1] = two_digits(fb_eff[2], fb_eff[3]);
          clock_d[2] = two_digits(fb_eff[4], fb_eff[5]);
        end else if (num == FLD_ZDA_DAY) begin
          clock_d[3] = two_digits(fb_eff[0], fb_eff[1]);
        end else if (num == FLD_ZDA_MONTH) begin
          clock_d[4] = two_digits(fb_eff[0], fb_eff[1]);
        end else if (num == FLD_ZDA_YEAR) begin
          year_d = four_digits(fb_eff[0], fb_eff[1], fb_eff[2], fb_eff[3]);
          if (fix_q != '0) begin
            time_d = hold_q;
          end
        end
      end else if (is_gsv) begin
        if ((num == FLD_GSV_SNR0 || num == FLD_GSV_SNR1 || num == FLD_GSV_SNR2 ||
             num == FLD_GSV_SNR3) && fb_eff[0] != 8'd0 && fb_eff[1] != 8'd0) begin
          if (cnt_q < SCW'(BEST_SATS)) begin
            for (int i = 0; i < BEST_SATS; i++) begin
              if (cnt_q == SCW'(i)) begin
                snr_d[i] = snr_new;
              end
            end
            cnt_d = cnt_q + SCW'(1);
          end else if (snr_new > vic_val) begin
            for (int i = 0; i < BEST_SATS; i++) begin
              if (vic_idx == SIW'(i)) begin
                snr_d[i] = snr_new;
              end
            end
          end
        end
      end
    end
  end

  // result built from the updated state
  always_comb begin
    out_d.utc_hours   = clock_d[0];
    out_d.utc_minutes = clock_d[1];
    out_d.utc_seconds = clock_d[2];
    out_d.utc_day     = clock_d[3];
    out_d.utc_month   = clock_d[4];
    out_d.utc_year    = year_d;
    out_d.fix_ok      = fix_d != '0;
    out_d.time_ok     = time_d != '0;
    out_d.signal_sum  = strength_d;
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= HOLD_RESET;
    end else if (cfg_we_i) begin
      hold_q <= cfg_wdata_i;
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= POS_IDLE;
      talker_q   <= '{default: '0};
      flen_q     <= '0;
      fbytes_q   <= '{default: '0};
      fix_q      <= '0;
      time_q     <= '0;
      cnt_q      <= '0;
      strength_q <= '0;
      clock_q    <= '{default: '0};
      year_q     <= '0;
    end else if (accept) begin
      pos_q      <= pos_d;
      talker_q   <= talker_d;
      flen_q     <= flen_d;
      fbytes_q   <= fbytes_d;
      fix_q      <= fix_d;
      time_q     <= time_d;
      cnt_q      <= cnt_d;
      strength_q <= strength_d;
      clock_q    <= clock_d;
      year_q     <= year_d;
    end
  end

  // snr entries, read only after being written
  always_ff @(posedge clk_i) begin
    if (accept) begin
      snr_q <= snr_d;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

`ifndef SYNTH
  // snr count never passes the list size
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= SCW'(BEST_SATS))
    else $error("snr count beyond list size");

  // field length never passes the field limit
  assert property (@(posedge clk_i) disable iff (!rst_ni) flen_q <= FLW'(FIELD_MAX))
    else $error("field length beyond limit");

  // a tick on an expired fix timer leaves it expired
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.data.kind == KIND_TICK && fix_q == '0) |=> (fix_q == '0))
    else $error("fix timer rearmed by a tick");

  // end of sentence returns the parser to idle with an empty field
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.data.kind == KIND_BYTE && in_i.data.rx_byte == CH_STAR)
    |=> (pos_q == POS_IDLE && flen_q == '0))
    else $error("parser not idle after end of sentence");

  // every transfer in leaves a result in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> out_valid_q)
    else $error("transfer without result");
`endif

endmodule

// ===== tb/nmea_time_fix_snr_parser_tb.sv =====
// testbench for the nmea time/fix/snr parser: sentence stimulus checked against a status predictor
module nmea_time_fix_snr_parser_tb;
  import ntfs_pkg::*;

  localparam int unsigned FIELD_LIMIT  = 32;
  localparam int unsigned SNR_SLOTS    = 5;
  localparam int unsigned PHASES       = 7;
  localparam int unsigned PHASE_ITEMS  = 150;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 4;

  // predicts the status output of the parser and checks every result transfer
  class nmea_status_tracker;
    bit [15:0]   hold_ms;
    bit [7:0]    pos;
    bit [7:0]    talker [3];
    bit [5:0]    flen;
    bit [7:0]    fbytes [KEPT_BYTES];
    bit [15:0]   fix_left;
    bit [15:0]   time_left;
    bit [7:0]    snr [SNR_SLOTS];
    bit [2:0]    snr_n;
    bit [10:0]   strength;
    bit [7:0]    hh, mm, ss, day, month;
    bit [15:0]   year;
    ntfs_out_t   status_q [$];
    int unsigned errors;

    function new();
      hold_ms = HOLD_RESET;
    endfunction

    function int unsigned pending();
      return status_q.size();
    endfunction

    // two ascii digits, wrapping at 8 bits
    function bit [7:0] pair_value(int unsigned i);
      bit [7:0] hi;
      bit [7:0] lo;
      hi = fbytes[i] - CH_ZERO;
      lo = fbytes[i + 1] - CH_ZERO;
      return hi * 8'd10 + lo;
    endfunction

    // four ascii digits, wrapping at 16 bits
    function bit [15:0] year_value();
      bit [15:0] d [4];
      for (int k = 0; k < 4; k++) d[k] = {8'd0, fbytes[k]} - {8'd0, CH_ZERO};
      return d[0] * 16'd1000 + d[1] * 16'd100 + d[2] * 16'd10 + d[3];
    endfunction

    function bit talker_is(bit [7:0] a, bit [7:0] b, bit [7:0] c);
      return talker[0] == a && talker[1] == b && talker[2] == c;
    endfunction

    // best-snr list: fill it, then a stronger value replaces the weakest entry below the limit
    function void take_snr();
      bit [7:0]    v;
      bit [7:0]    low;
      int unsigned at;
      v = pair_value(0);
      if (snr_n < SNR_SLOTS) begin
        snr[snr_n] = v;
        snr_n++;
      end else begin
        low = SNR_LIMIT;
        at = 0;
        for (int i = 0; i < SNR_SLOTS; i++) begin
          if (snr[i] < low) begin
            low = snr[i];
            at = i;
          end
        end
        if (v > snr[at]) snr[at] = v;
      end
    endfunction

    // act on a field that has just ended
    function void close_field();
      bit [7:0]  num;
      bit [11:0] sum;
      if (flen == 0 || flen >= FIELD_LIMIT) return;
      if (flen < KEPT_BYTES) fbytes[flen] = 8'd0;
      num = pos - FIELD_BASE;
      if (talker_is(CH_G, CH_G, CH_A)) begin
        if (num == FLD_GGA_QUALITY) begin
          fix_left = (fbytes[0] == CH_ONE && fbytes[1] == 8'd0) ? hold_ms : 16'd0;
        end else if (num == FLD_FIRST) begin
          sum = '0;
          for (int i = 0; i < snr_n && i < SNR_SLOTS; i++) sum += snr[i];
          strength = sum[10:0];
          snr_n = '0;
        end
      end else if (talker_is(CH_Z, CH_D, CH_A)) begin
        if (num == FLD_FIRST) begin
          hh = pair_value(0);
          mm = pair_value(2);
          ss = pair_value(4);
        end else if (num == FLD_ZDA_DAY) begin
          day = pair_value(0);
        end else if (num == FLD_ZDA_MONTH) begin
          month = pair_value(0);
        end else if (num == FLD_ZDA_YEAR) begin
          year = year_value();
          if (fix_left != 0) time_left = hold_ms;
        end
      end else if (talker_is(CH_G, CH_S, CH_V)) begin
        if ((num == FLD_GSV_SNR0 || num == FLD_GSV_SNR1 || num == FLD_GSV_SNR2 ||
             num == FLD_GSV_SNR3) && fbytes[0] != 0 && fbytes[1] != 0) begin
          take_snr();
        end
      end
    endfunction

    // sentence framing
    function void take_byte(bit [7:0] c);
      if (c == CH_DOLLAR) begin
        pos = POS_START;
      end else if (c == CH_STAR) begin
        close_field();
        flen = 0;
        pos = POS_IDLE;
      end else if (pos != POS_IDLE) begin
        if (pos < POS_FIELDS) begin
          if (pos >= POS_ID_FIRST) talker[pos - POS_ID_FIRST] = c;
          pos++;
        end else if (c == CH_COMMA) begin
          close_field();
          flen = 0;
          pos++;
        end else if (flen < FIELD_LIMIT) begin
          if (flen < KEPT_BYTES) fbytes[flen] = c;
          flen++;
        end
      end
    endfunction

    // accepted input transfer: update state and queue the status it leads to
    function void take_item(ntfs_in_t it);
      ntfs_out_t st;
      if (it.kind == KIND_TICK) begin
        if (fix_left != 0) fix_left--;
        if (time_left != 0) time_left--;
      end else begin
        take_byte(it.rx_byte);
      end
      st.utc_hours   = hh;
      st.utc_minutes = mm;
      st.utc_seconds = ss;
      st.utc_day     = day;
      st.utc_month   = month;
      st.utc_year    = year;
      st.fix_ok      = (fix_left != 0);
      st.time_ok     = (time_left != 0);
      st.signal_sum  = strength;
      status_q.push_back(st);
    endfunction

    function void diff(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    // accepted result transfer: compare with the oldest prediction
    function void check_status(ntfs_out_t got);
      ntfs_out_t want;
      if (status_q.size() == 0) begin
        $error("result transfer with no pending prediction");
        errors++;
        return;
      end
      want = status_q.pop_front();
      diff("utc_hours", want.utc_hours, got.utc_hours);
      diff("utc_minutes", want.utc_minutes, got.utc_minutes);
      diff("utc_seconds", want.utc_seconds, got.utc_seconds);
      diff("utc_day", want.utc_day, got.utc_day);
      diff("utc_month", want.utc_month, got.utc_month);
      diff("utc_year", want.utc_year, got.utc_year);
      diff("fix_ok", want.fix_ok, got.fix_ok);
      diff("time_ok", want.time_ok, got.time_ok);
      diff("signal_sum", want.signal_sum, got.signal_sum);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;

  ntfs_in_if  in_ch ();
  ntfs_out_if out_ch ();

  nmea_time_fix_snr_parser u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  nmea_status_tracker tracker;
  logic [7:0]         line_q [$];
  int unsigned        burst_left;
  int unsigned        items_sent;
  int unsigned        quiet_cycles = 0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // transfer monitor and quiet-cycle counter
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) tracker.check_status(out_ch.data);
    if (rst_ni && in_ch.valid && in_ch.ready) tracker.take_item(in_ch.data);
    if (rst_ni && ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready))) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // watchdog
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("Verification failed");
    $finish;
  end

  // receiver back-pressure in segments of varying stall density
  initial begin : rx_stall
    int unsigned stall_pct;
    int unsigned span;
    out_ch.ready = 1'b0;
    forever begin
      case ($urandom_range(0, 3))
        0:       stall_pct = 0;
        1:       stall_pct = 25;
        2:       stall_pct = 50;
        default: stall_pct = 85;
      endcase
      span = $urandom_range(10, 150);
      repeat (span) begin
        @(negedge clk_i);
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // one input transfer, with burst gaps in between
  task automatic send_item(input kind_e kind, input logic [7:0] value);
    int unsigned gap;
    ntfs_in_t    it;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    it.kind = kind;
    it.rx_byte = value;
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic send_tick();
    send_item(KIND_TICK, 8'($urandom_range(0, 255)));
  endtask

  // send the buffered sentence, with ticks mixed in
  task automatic send_line(input int unsigned tick_pct);
    foreach (line_q[i]) begin
      if ($urandom_range(0, 99) < tick_pct) send_tick();
      send_item(KIND_BYTE, line_q[i]);
    end
    line_q.delete();
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic put_digits(input int unsigned n);
    repeat (n) line_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
  endtask

  function automatic logic [7:0] field_noise();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_DOLLAR || b == CH_STAR || b == CH_COMMA);
    return b;
  endfunction

  // field content: mostly digits of the usual length, else empty, odd length, junk or overlong
  task automatic put_field(input int unsigned n);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      put_digits(n);
    end else if (pick >= 80) begin
      if (pick < 88) put_digits($urandom_range(1, 6));
      else if (pick < 95) repeat ($urandom_range(1, 6)) line_q.push_back(field_noise());
      else put_digits($urandom_range(30, 36));
    end
  endtask

  task automatic put_start(input string id3);
    line_q.push_back(CH_DOLLAR);
    line_q.push_back(CH_G);
    line_q.push_back(8'(CH_A + $urandom_range(0, 25)));
    put_text(id3);
  endtask

  // star, checksum characters and an optional line end
  task automatic put_end();
    int unsigned v;
    line_q.push_back(CH_STAR);
    repeat (2) begin
      v = $urandom_range(0, 15);
      line_q.push_back((v < 10) ? 8'(CH_ZERO + v) : 8'(CH_A + v - 10));
    end
    if ($urandom_range(0, 1)) begin
      line_q.push_back(8'h0D);
      line_q.push_back(8'h0A);
    end
  endtask

  task automatic put_zda();
    put_start("ZDA");
    put_text(",");
    put_field(6);
    if ($urandom_range(0, 1)) put_text(".00");
    put_text(",");
    put_field(2);
    put_text(",");
    put_field(2);
    put_text(",");
    put_field(4);
    put_text(",00,00");
    put_end();
  endtask

  task automatic put_gga();
    int unsigned pick;
    put_start("GGA");
    put_text(",");
    put_field(6);
    put_text(",");
    put_field(4);
    put_text(",N,");
    put_field(5);
    put_text(",E,");
    pick = $urandom_range(0, 9);
    if (pick < 6) put_text("1");
    else if (pick == 6) put_text("0");
    else if (pick == 7) put_text("2");
    else if (pick == 8) begin
      put_text("1");
      put_digits(1);
    end else put_field(1);
    put_text(",");
    put_field(2);
    put_text(",1.0,10.0,M,0.0,M,,");
    put_end();
  endtask

  task automatic put_gsv();
    int unsigned sats;
    put_start("GSV");
    put_text(",");
    put_field(1);
    put_text(",");
    put_field(1);
    put_text(",");
    put_field(2);
    sats = $urandom_range(0, 4);
    repeat (sats) begin
      put_text(",");
      put_field(2);
      put_text(",");
      put_field(2);
      put_text(",");
      put_field(3);
      put_text(",");
      put_field(2);
    end
    put_end();
  endtask

  // unknown sentence id
  task automatic put_other();
    line_q.push_back(CH_DOLLAR);
    repeat (5) line_q.push_back(8'(CH_A + $urandom_range(0, 25)));
    repeat ($urandom_range(0, 5)) begin
      put_text(",");
      put_field(3);
    end
    put_end();
  endtask

  // enough commas to wrap the parse position back to idle
  task automatic put_flood();
    put_start("GSV");
    repeat (260) begin
      if ($urandom_range(0, 9) == 0) put_digits(2);
      put_text(",");
    end
    put_text("1");
    put_end();
  endtask

  task automatic random_sentence();
    int unsigned pick;
    int unsigned cut;
    pick = $urandom_range(0, 99);
    if (pick < 25) put_zda();
    else if (pick < 50) put_gga();
    else if (pick < 75) put_gsv();
    else if (pick < 82) put_other();
    else if (pick < 90) repeat ($urandom_range(1, 8)) line_q.push_back(8'($urandom_range(0, 255)));
    else begin
      // sentence cut short, the next one restarts the parser
      case ($urandom_range(0, 2))
        0:       put_zda();
        1:       put_gga();
        default: put_gsv();
      endcase
      cut = $urandom_range(1, line_q.size() - 1);
      while (line_q.size() > cut) void'(line_q.pop_back());
    end
    send_line($urandom_range(0, 20));
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 60)) send_tick();
  endtask

  // stop sending and wait until every prediction has been matched
  task automatic settle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_hold(input logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.hold_ms = value;
    @(negedge clk_i);
  endtask

  // main sequence
  initial begin
    int unsigned target;
    logic [15:0] hold_v;
    tracker     = new();
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    burst_left  = 0;
    items_sent  = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part at the reset hold time
    put_text("xyz$GPGGA,,,,,,1*");
    put_text("$GPZDA,235959,31,12,2099*4E");
    line_q.push_back(8'h0D);
    line_q.push_back(8'h0A);
    send_line(0);
    // non-digit characters in the time, day and year fields, with an empty month field
    put_text("$GPZDA,:;/~A,");
    line_q.push_back(8'hFF);
    line_q.push_back(8'h00);
    put_text(",,");
    line_q.push_back(8'h80);
    line_q.push_back(8'h7F);
    line_q.push_back(8'h01);
    line_q.push_back(8'hFE);
    put_text("*");
    send_line(0);
    // fill the snr list, then replace its weakest entry; single digit is ignored
    put_text("$GPGSV,,,,,,,45,,,,99,,,,07,,,,12*$GPGSV,,,,,,,80,,,,05,,,,9*$GPGSV,,,,,,,50*");
    put_text("$GPGGA,1,,,,,2*");
    send_line(0);
    // every entry at or above the limit, so the first one is replaced
    put_text("$GPGSV,,,,,,,::,,,,;;,,,,<<,,,,==*$GPGSV,,,,,,,>>,,,,??*$GPGGA,0,,,,,1*");
    send_line(0);
    // short field reads stale bytes, overlong quality field is skipped
    put_text("$GPZDA,1*$GPGGA,,,,,,1");
    repeat (31) line_q.push_back(CH_ZERO);
    put_text("*");
    send_line(0);
    // restart inside a sentence
    put_text("$GPZD$GPGGA,,,,,,0*$GPGGA,,,,,,1$GPZDA*$GPZDA,,,,1999*");
    send_line(0);
    repeat (3) send_tick();

    // random phases, each at its own hold time
    for (int p = 1; p < PHASES; p++) begin
      settle();
      case (p)
        1:       hold_v = 16'd0;
        2:       hold_v = 16'hFFFF;
        3:       hold_v = 16'd1;
        default: hold_v = 16'($urandom_range(2, 120));
      endcase
      write_hold(hold_v);
      if (p == PHASES - 1) begin
        put_flood();
        send_line(0);
      end
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) random_sentence();
    end

    settle();
    if (tracker.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
